[design/arm_forward_kinematics_defines.svh]
// Assertion macros for the arm forward kinematics top level.
`ifndef ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AFK_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AFK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/afk_pkg.sv]
// Types, constants and pipeline figures shared by the forward kinematics design.
package afk_pkg;

  localparam int ANG_W     = 16;
  localparam int TRIG_W    = 18;
  localparam int ROT_W     = 20;
  localparam int LEN_W     = 32;
  localparam int POS_W     = 38;
  localparam int OUT_ROT_W = 18;
  localparam int OUT_POS_W = 32;

  // Angle reduction constants in Q2.30.
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;

  // Horner divisors of the sine and cosine series.
  localparam int HORNER_STEPS = 5;
  localparam int unsigned SIN_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12};

  localparam int NUM_JOINTS = 6;
  // Joints turning about Z (others turn about Y), and joints carrying a link.
  localparam logic [NUM_JOINTS-1:0] JOINT_AXIS_Z   = 6'b101001;
  localparam logic [NUM_JOINTS-1:0] JOINT_HAS_LINK = 6'b100101;

  // Pipeline depths.
  localparam int SC_LAT     = 2 + 2 * HORNER_STEPS + 2;
  localparam int STEP_LAT   = 2;
  localparam int PIPE_DEPTH = SC_LAT + (NUM_JOINTS - 1) * STEP_LAT + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_BASE  = 2'd0,
    REG_LINK_UPPER = 2'd1,
    REG_LINK_TOOL  = 2'd2
  } cfg_reg_t;

  typedef logic signed [ANG_W-1:0]     ang_t;
  typedef logic signed [TRIG_W-1:0]    trig_t;
  typedef logic signed [ROT_W-1:0]     rot_t;
  typedef logic signed [LEN_W-1:0]     len_t;
  typedef logic signed [POS_W-1:0]     pos_t;
  typedef logic signed [OUT_ROT_W-1:0] out_rot_t;
  typedef logic signed [OUT_POS_W-1:0] out_pos_t;

  typedef rot_t rot_mat_t [9];
  typedef pos_t pos_vec_t [3];

endpackage

[design/afk_ifs.sv]
// Request channel interfaces: joint angles in, pose out, link length writes.
interface afk_in_if import afk_pkg::*; ();
  logic valid;
  logic ready;
  ang_t angle_j0;
  ang_t angle_j1;
  ang_t angle_j2;
  ang_t angle_j3;
  ang_t angle_j4;
  ang_t angle_j5;

  modport source (output valid, output angle_j0, output angle_j1, output angle_j2,
                  output angle_j3, output angle_j4, output angle_j5, input ready);
  modport sink (input valid, input angle_j0, input angle_j1, input angle_j2,
                input angle_j3, input angle_j4, input angle_j5, output ready);
endinterface

interface afk_out_if import afk_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rot_t rot_r0c0;
  out_rot_t rot_r0c1;
  out_rot_t rot_r0c2;
  out_rot_t rot_r1c0;
  out_rot_t rot_r1c1;
  out_rot_t rot_r1c2;
  out_rot_t rot_r2c0;
  out_rot_t rot_r2c1;
  out_rot_t rot_r2c2;
  out_pos_t pos_x;
  out_pos_t pos_y;
  out_pos_t pos_z;

  modport source (output valid, output rot_r0c0, output rot_r0c1, output rot_r0c2,
                  output rot_r1c0, output rot_r1c1, output rot_r1c2, output rot_r2c0,
                  output rot_r2c1, output rot_r2c2, output pos_x, output pos_y,
                  output pos_z, input ready);
  modport sink (input valid, input rot_r0c0, input rot_r0c1, input rot_r0c2,
                input rot_r1c0, input rot_r1c1, input rot_r1c2, input rot_r2c0,
                input rot_r2c1, input rot_r2c2, input pos_x, input pos_y,
                input pos_z, output ready);
endinterface

interface afk_cfg_if import afk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/afk_sincos.sv]
// Pipelined fixed-point sine and cosine of one Q3.13 angle, Q1.16 results.
module afk_sincos import afk_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ang_t  angle,
  output trig_t sin_q,
  output trig_t cos_q
);

  typedef struct packed {
    logic [30:0] m;
    logic        neg;
    logic        flip;
  } ctx_t;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Stage 0: fold the angle into [-pi/2, pi/2] and take its magnitude.
  logic signed [35:0] r_full;
  logic signed [35:0] r_red;
  logic               flip0;
  logic [35:0]        mag0;
  ctx_t               ctx0_r;

  always_comb begin
    r_full = {{3{angle[ANG_W-1]}}, angle, 17'b0};
    flip0  = 1'b1;
    if (r_full > Q30_HALF_PI) begin
      r_red = r_full - Q30_PI;
    end else if (r_full < -Q30_HALF_PI) begin
      r_red = r_full + Q30_PI;
    end else begin
      r_red = r_full;
      flip0 = 1'b0;
    end
    mag0 = r_red[35] ? 36'(-r_red) : 36'(r_red);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r <= '{m: mag0[30:0], neg: r_red[35], flip: flip0};
    end
  end

  // Stage 1: square of the magnitude.
  ctx_t        ctx1_r;
  logic [61:0] mm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx0_r;
      mm_r   <= {31'b0, ctx0_r.m} * {31'b0, ctx0_r.m};
    end
  end

  // Horner steps for both series: a product stage, then a constant division.
  logic [62:0] ps_a_r [HORNER_STEPS];
  logic [62:0] pc_a_r [HORNER_STEPS];
  logic [31:0] za_r   [HORNER_STEPS];
  ctx_t        ctxa_r [HORNER_STEPS];
  logic [31:0] qs_b_r [HORNER_STEPS];
  logic [31:0] qc_b_r [HORNER_STEPS];
  logic [31:0] zb_r   [HORNER_STEPS];
  ctx_t        ctxb_r [HORNER_STEPS];

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    // Reciprocal constants, exact for every 32-bit dividend.
    localparam int          KS = int'(SIN_DIV[i]);
    localparam int          KC = int'(COS_DIV[i]);
    localparam int          SS = 32 + $clog2(KS);
    localparam int          SC = 32 + $clog2(KC);
    localparam logic [64:0] RS = ((65'd1 << SS) + 65'(KS) - 65'd1) / 65'(KS);
    localparam logic [64:0] RC = ((65'd1 << SC) + 65'(KC) - 65'd1) / 65'(KC);

    logic [31:0] z_in;
    logic [31:0] qs_in;
    logic [31:0] qc_in;
    ctx_t        ctx_in;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [31:0] ps_div;
    logic [31:0] pc_div;

    if (i == 0) begin : g_first
      assign z_in   = mm_r[61:30];
      assign qs_in  = '0;
      assign qc_in  = '0;
      assign ctx_in = ctx1_r;
    end else begin : g_next
      assign z_in   = zb_r[i-1];
      assign qs_in  = qs_b_r[i-1];
      assign qc_in  = qc_b_r[i-1];
      assign ctx_in = ctxb_r[i-1];
    end

    assign ts     = 31'(Q30_ONE - qs_in);
    assign tc     = 31'(Q30_ONE - qc_in);
    assign ps_div = ps_a_r[i][61:30];
    assign pc_div = pc_a_r[i][61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        ps_a_r[i] <= {31'b0, z_in} * {32'b0, ts};
        pc_a_r[i] <= {31'b0, z_in} * {32'b0, tc};
        za_r[i]   <= z_in;
        ctxa_r[i] <= ctx_in;
        qs_b_r[i] <= 32'(({33'b0, ps_div} * RS) >> SS);
        qc_b_r[i] <= 32'(({33'b0, pc_div} * RC) >> SC);
        zb_r[i]   <= za_r[i];
        ctxb_r[i] <= ctxa_r[i];
      end
    end
  end

  // Final products: m * t for sine, z * t for the last cosine term.
  logic [30:0] ts_fin;
  logic [30:0] tc_fin;
  logic [61:0] sp_r;
  logic [62:0] cp_r;
  ctx_t        ctxx_r;

  assign ts_fin = 31'(Q30_ONE - qs_b_r[HORNER_STEPS-1]);
  assign tc_fin = 31'(Q30_ONE - qc_b_r[HORNER_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r   <= {31'b0, ctxb_r[HORNER_STEPS-1].m} * {31'b0, ts_fin};
      cp_r   <= {31'b0, zb_r[HORNER_STEPS-1]} * {32'b0, tc_fin};
      ctxx_r <= ctxb_r[HORNER_STEPS-1];
    end
  end

  // Round to Q1.16, clamp the cosine at zero and apply the signs.
  logic [32:0]        s_round;
  logic signed [33:0] cm;
  logic [32:0]        c_round;
  trig_t              s_mag;
  trig_t              c_mag;
  trig_t              s_val;
  trig_t              c_val;
  trig_t              sin_r;
  trig_t              cos_r;

  always_comb begin
    s_round = {1'b0, sp_r[61:30]} + 33'd8192;
    cm      = 34'sh4000_0000 - 34'($unsigned(cp_r[62:31]));
    if (cm < 0) begin
      c_round = 33'd8192;
    end else begin
      c_round = 33'(cm) + 33'd8192;
    end
    s_mag = trig_t'(s_round[32:14]);
    c_mag = trig_t'(c_round[32:14]);
    s_val = ctxx_r.neg ? -s_mag : s_mag;
    c_val = c_mag;
    if (ctxx_r.flip) begin
      s_val = -s_val;
      c_val = -c_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= s_val;
      cos_r <= c_val;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

[design/afk_rotstep.sv]
// One joint of the chain: rotation product and optional link translation, two stages.
module afk_rotstep import afk_pkg::*; #(
  parameter bit AXIS_Z   = 1'b1,
  parameter bit HAS_LINK = 1'b0
) (
  input  logic     clk,
  input  logic     en,
  input  rot_mat_t rot_i,
  input  pos_vec_t pos_i,
  input  trig_t    sin_i,
  input  trig_t    cos_i,
  input  len_t     len_i,
  output rot_mat_t rot_o,
  output pos_vec_t pos_o
);

  localparam int PROD_W  = ROT_W + TRIG_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int LPROD_W = ROT_W + LEN_W;
  localparam int COL_Q   = AXIS_Z ? 1 : 2;
  localparam int COL_K   = AXIS_Z ? 2 : 1;

  // About Y the sine enters the first column with the opposite sign.
  logic signed [TRIG_W:0] s_eff;
  assign s_eff = AXIS_Z ? {sin_i[TRIG_W-1], sin_i} : -{sin_i[TRIG_W-1], sin_i};

  logic signed [PROD_W-1:0]  pc_r [3];
  logic signed [PROD_W-1:0]  qs_r [3];
  logic signed [PROD_W-1:0]  qc_r [3];
  logic signed [PROD_W-1:0]  ps_r [3];
  rot_t                      keep_r [3];
  logic signed [LPROD_W-1:0] link_r [3];
  pos_t                      pos1_r [3];
  rot_t                      rot2_r [9];
  pos_t                      pos2_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_row
    logic signed [SUM_W-1:0]   sum_p;
    logic signed [SUM_W-1:0]   sum_q;
    logic signed [LPROD_W:0]   lsum;

    // Rounded half up, then scaled back to Q1.16.
    assign sum_p = SUM_W'(pc_r[a]) + SUM_W'(qs_r[a]) + SUM_W'(1 <<< 15);
    assign sum_q = SUM_W'(qc_r[a]) - SUM_W'(ps_r[a]) + SUM_W'(1 <<< 15);
    assign lsum  = (LPROD_W+1)'(link_r[a]) + (LPROD_W+1)'(1 <<< 15);

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[a]   <= PROD_W'(rot_i[a*3]) * PROD_W'(cos_i);
        qs_r[a]   <= PROD_W'(rot_i[a*3+COL_Q]) * PROD_W'(s_eff);
        qc_r[a]   <= PROD_W'(rot_i[a*3+COL_Q]) * PROD_W'(cos_i);
        ps_r[a]   <= PROD_W'(rot_i[a*3]) * PROD_W'(s_eff);
        keep_r[a] <= rot_i[a*3+COL_K];
        pos1_r[a] <= pos_i[a];
        link_r[a] <= HAS_LINK ? LPROD_W'(rot_i[a*3+2]) * LPROD_W'(len_i) : '0;

        rot2_r[a*3]       <= rot_t'(sum_p >>> 16);
        rot2_r[a*3+COL_Q] <= rot_t'(sum_q >>> 16);
        rot2_r[a*3+COL_K] <= keep_r[a];
        pos2_r[a]         <= pos1_r[a] + pos_t'(lsum >>> 16);
      end
    end
  end

  assign rot_o = rot2_r;
  assign pos_o = pos2_r;

endmodule

[design/arm_forward_kinematics.sv]
// Top level: six-joint forward kinematics pipeline with link length registers.
//
// Use: six Q3.13 joint angles enter as one request on in_ch; the pose leaves
// as one request on out_ch: a 3x3 rotation in Q1.16 and a Q16.16 position
// that saturates at the 32-bit limits. Link lengths for the base, upper and
// tool links are written on cfg_ch (index 0, 1, 2; other indexes are
// dropped); the user writes them only while no request is in flight, which
// the block does not enforce. cfg_ch is always ready. Throughput is one
// request per cycle while no result waits on the receiver. A request passes,
// from acceptance to the result showing on out_ch, through sine/cosine
// evaluation (five Horner steps, each a product and a reciprocal division
// stage), then the five chained joint products, then the saturating output register.
// When the receiver holds off a waiting result, the whole pipeline freezes
// and in_ch.ready drops; nothing is lost or repeated. A synchronous reset on
// rst_n clears every valid bit and sets all link lengths to zero.
module arm_forward_kinematics import afk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  afk_in_if.sink    in_ch,
  afk_out_if.source out_ch,
  afk_cfg_if.sink   cfg_ch
);

`include "arm_forward_kinematics_defines.svh"

  // Link length registers.
  len_t len_base_r;
  len_t len_upper_r;
  len_t len_tool_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_base_r  <= '0;
      len_upper_r <= '0;
      len_tool_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LINK_BASE:  len_base_r  <= len_t'(cfg_ch.data);
        REG_LINK_UPPER: len_upper_r <= len_t'(cfg_ch.data);
        REG_LINK_TOOL:  len_tool_r  <= len_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result waits on the receiver.
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;

  assign adv         = !vld_r[PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // Each angle is delayed so its sine and cosine arrive with its joint step.
  ang_t  ang_in [NUM_JOINTS];
  trig_t sin_q  [NUM_JOINTS];
  trig_t cos_q  [NUM_JOINTS];

  assign ang_in[0] = in_ch.angle_j0;
  assign ang_in[1] = in_ch.angle_j1;
  assign ang_in[2] = in_ch.angle_j2;
  assign ang_in[3] = in_ch.angle_j3;
  assign ang_in[4] = in_ch.angle_j4;
  assign ang_in[5] = in_ch.angle_j5;

  for (genvar k = 0; k < NUM_JOINTS; k++) begin : g_joint
    localparam int DLY = (k < 2) ? 0 : STEP_LAT * (k - 1);
    ang_t ang_d;

    if (DLY == 0) begin : g_direct
      assign ang_d = ang_in[k];
    end else begin : g_delay
      ang_t dl_r [DLY];
      always_ff @(posedge clk) begin
        if (adv) begin
          dl_r[0] <= ang_in[k];
          for (int j = 1; j < DLY; j++) begin
            dl_r[j] <= dl_r[j-1];
          end
        end
      end
      assign ang_d = dl_r[DLY-1];
    end

    afk_sincos u_sincos (
      .clk   (clk),
      .en    (adv),
      .angle (ang_d),
      .sin_q (sin_q[k]),
      .cos_q (cos_q[k])
    );
  end

  // The first joint's transform stands alone: its rotation and base offset.
  rot_mat_t rot_s [NUM_JOINTS];
  pos_vec_t pos_s [NUM_JOINTS];

  assign rot_s[0] = '{rot_t'(cos_q[0]), -rot_t'(sin_q[0]), rot_t'(0),
                      rot_t'(sin_q[0]), rot_t'(cos_q[0]), rot_t'(0),
                      rot_t'(0), rot_t'(0), rot_t'(1 <<< 16)};
  assign pos_s[0] = '{pos_t'(0), pos_t'(0), pos_t'(len_base_r)};

  // Chained joint products.
  for (genvar k = 1; k < NUM_JOINTS; k++) begin : g_chain
    afk_rotstep #(
      .AXIS_Z   (JOINT_AXIS_Z[k]),
      .HAS_LINK (JOINT_HAS_LINK[k])
    ) u_step (
      .clk   (clk),
      .en    (adv),
      .rot_i (rot_s[k-1]),
      .pos_i (pos_s[k-1]),
      .sin_i (sin_q[k]),
      .cos_i (cos_q[k]),
      .len_i ((k == 2) ? len_upper_r : len_tool_r),
      .rot_o (rot_s[k]),
      .pos_o (pos_s[k])
    );
  end

  // Saturating output register.
  localparam rot_t ROT_HI = rot_t'((1 <<< (OUT_ROT_W - 1)) - 1);
  localparam rot_t ROT_LO = rot_t'(-(1 <<< (OUT_ROT_W - 1)));
  localparam pos_t POS_HI = pos_t'((64'sd1 <<< (OUT_POS_W - 1)) - 64'sd1);
  localparam pos_t POS_LO = pos_t'(-(64'sd1 <<< (OUT_POS_W - 1)));

  function automatic out_rot_t sat_rot(rot_t v);
    rot_t c;
    c = (v > ROT_HI) ? ROT_HI : ((v < ROT_LO) ? ROT_LO : v);
    return out_rot_t'(c);
  endfunction

  function automatic out_pos_t sat_pos(pos_t v);
    pos_t c;
    c = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
    return out_pos_t'(c);
  endfunction

  out_rot_t rot_out_r [9];
  out_pos_t pos_out_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        rot_out_r[i] <= sat_rot(rot_s[NUM_JOINTS-1][i]);
      end
      for (int i = 0; i < 3; i++) begin
        pos_out_r[i] <= sat_pos(pos_s[NUM_JOINTS-1][i]);
      end
    end
  end

  assign out_ch.valid    = vld_r[PIPE_DEPTH-1];
  assign out_ch.rot_r0c0 = rot_out_r[0];
  assign out_ch.rot_r0c1 = rot_out_r[1];
  assign out_ch.rot_r0c2 = rot_out_r[2];
  assign out_ch.rot_r1c0 = rot_out_r[3];
  assign out_ch.rot_r1c1 = rot_out_r[4];
  assign out_ch.rot_r1c2 = rot_out_r[5];
  assign out_ch.rot_r2c0 = rot_out_r[6];
  assign out_ch.rot_r2c1 = rot_out_r[7];
  assign out_ch.rot_r2c2 = rot_out_r[8];
  assign out_ch.pos_x    = pos_out_r[0];
  assign out_ch.pos_y    = pos_out_r[1];
  assign out_ch.pos_z    = pos_out_r[2];

  // A waiting result must hold off new requests.
  `AFK_ASSERT_NOW(a_stall_blocks_input, vld_r[PIPE_DEPTH-1] && !out_ch.ready, !in_ch.ready, "request accepted while result stalled")
  // A frozen pipeline keeps every valid bit where it was.
  `AFK_ASSERT_NEXT(a_freeze_holds_valid, !adv, vld_r == $past(vld_r), "valid bits moved during stall")
  // An accepted request enters the first stage.
  `AFK_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0], "accepted request lost at entry")
  // Bits advance one stage per cycle of progress.
  `AFK_ASSERT_NEXT(a_valid_shifts, adv && vld_r[SC_LAT], vld_r[SC_LAT+1], "valid bit dropped inside pipeline")

endmodule
